/* hdl/cad_pkg.sv */
// Shared types and codes for the connection affinity dispatcher.
// No dependencies; every other file of the block imports this package.
package cad_pkg;

  localparam int CONN_W   = 10;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int WORKER_W = 2;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_Q_PRIV      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_Q_SHARED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FROM_PRIV   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FROM_SHARED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE        = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STOPPED     = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic access;
    logic load;
  } cmd_t;

  // datapath / ports -> controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } sts_t;

endpackage

/* hdl/cad_req_if.sv */
// Request channel: submit or fetch items into the dispatcher.
// Depends on cad_pkg for field widths.
interface cad_req_if import cad_pkg::*;;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [CONN_W-1:0]   conn_id;
  logic [TAG_W-1:0]    client_tag;
  logic [TAG_W-1:0]    item_tag;
  logic [WORKER_W-1:0] worker;

  modport source (output valid, opcode, conn_id, client_tag, item_tag, worker,
                  input ready);
  modport sink (input valid, opcode, conn_id, client_tag, item_tag, worker,
                output ready);
endinterface

/* hdl/cad_rsp_if.sv */
// Response channel: one result per request.
// Depends on cad_pkg for field widths.
interface cad_rsp_if import cad_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORKER_W-1:0] target_worker;
  logic [CONN_W-1:0]   out_conn_id;
  logic [TAG_W-1:0]    out_client_tag;
  logic [TAG_W-1:0]    out_item_tag;

  modport source (output valid, status, target_worker, out_conn_id, out_client_tag,
                  out_item_tag, input ready);
  modport sink (input valid, status, target_worker, out_conn_id, out_client_tag,
                out_item_tag, output ready);
endinterface

/* hdl/cad_ctrl.sv */
// Sequencer of the dispatcher: capture, lookup, access, finish.
// Depends on cad_pkg (cmd_t, sts_t).
module cad_ctrl import cad_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, LOOKUP, ACCESS, FINISH} state_t;

  state_t state;

  assign cmd.capture = sts.in_valid & in_ready;
  assign cmd.lookup  = (state == LOOKUP);
  assign cmd.access  = (state == ACCESS);
  assign cmd.load    = (state == FINISH) & sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.capture) begin
            state    <= LOOKUP;
            in_ready <= 1'b0;
          end
        end
        LOOKUP: state <= ACCESS;
        ACCESS: state <= FINISH;
        FINISH: begin
          // hold until the output register can take the result
          if (sts.out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

/* hdl/cad_datapath.sv */
// Datapath: binding table, per-worker and shared FIFOs, halt register, result register.
// Depends on cad_pkg; driven by cad_ctrl commands.
module cad_datapath import cad_pkg::*; #(
  parameter int WORKERS       = 4,
  parameter int PRIVATE_DEPTH = 16,
  parameter int SHARED_DEPTH  = 64,
  parameter int CONN_BITS     = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                opcode,
  input  logic [CONN_W-1:0]   conn_id,
  input  logic [TAG_W-1:0]    client_tag,
  input  logic [TAG_W-1:0]    item_tag,
  input  logic [WORKER_W-1:0] worker,
  input  logic                out_ready,
  output logic                out_free,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [WORKER_W-1:0] target_worker,
  output logic [CONN_W-1:0]   out_conn_id,
  output logic [TAG_W-1:0]    out_client_tag,
  output logic [TAG_W-1:0]    out_item_tag
);

  localparam int CW = (CONN_BITS < CONN_W) ? CONN_BITS : CONN_W;
  localparam int WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int PB = $clog2(PRIVATE_DEPTH);
  localparam int SB = $clog2(SHARED_DEPTH);
  localparam int PC = $clog2(PRIVATE_DEPTH + 1);
  localparam int SC = $clog2(SHARED_DEPTH + 1);
  localparam int IW = CW + 2 * TAG_W;

  localparam logic [PC-1:0] P_FULL = PC'(PRIVATE_DEPTH);
  localparam logic [SC-1:0] S_FULL = SC'(SHARED_DEPTH);
  localparam logic [PB-1:0] P_LAST = PB'(PRIVATE_DEPTH - 1);
  localparam logic [SB-1:0] S_LAST = SB'(SHARED_DEPTH - 1);

  // captured request
  logic                op_q;
  logic [CW-1:0]       conn_q;
  logic [TAG_W-1:0]    client_q;
  logic [TAG_W-1:0]    tag_q;
  logic [WORKER_W-1:0] wk_q;

  logic          halt;
  logic          bind_valid [WORKERS];
  logic [CW-1:0] bind_conn  [WORKERS];

  logic [PB-1:0] phead  [WORKERS];
  logic [PB-1:0] ptail  [WORKERS];
  logic [PC-1:0] pcount [WORKERS];
  logic [SB-1:0] shead;
  logic [SB-1:0] stail;
  logic [SC-1:0] scount;

  logic [IW-1:0] pmem [2**(WB+PB)];
  logic [IW-1:0] smem [2**SB];
  logic [IW-1:0] prd;
  logic [IW-1:0] srd;

  logic          hit, hit_q;
  logic [WB-1:0] hit_idx, hit_idx_q;

  logic [STATUS_W-1:0] acc_status, res_status;
  logic [WORKER_W-1:0] acc_worker, res_worker;
  logic                p_we, p_re, s_we, s_re, clr_bind;
  logic [WB-1:0]       p_sel, widx;
  logic                wk_ok;
  logic [WB+PB-1:0]    p_addr;
  logic [SB-1:0]       s_addr;
  logic [IW-1:0]       item_q;

  assign item_q   = {conn_q, client_q, tag_q};
  assign widx     = WB'(wk_q);
  assign wk_ok    = 32'(wk_q) < WORKERS;
  assign out_free = !out_valid || out_ready;

  // lowest-numbered bound worker wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      if (bind_valid[i] && bind_conn[i] == conn_q) begin
        hit     = 1'b1;
        hit_idx = WB'(i);
      end
    end
  end

  always_comb begin
    acc_status = ST_NONE;
    acc_worker = wk_q;
    p_we       = 1'b0;
    p_re       = 1'b0;
    s_we       = 1'b0;
    s_re       = 1'b0;
    clr_bind   = 1'b0;
    p_sel      = widx;
    if (op_q == OP_SUBMIT) begin
      if (hit_q) begin
        acc_worker = WORKER_W'(hit_idx_q);
        p_sel      = hit_idx_q;
        if (pcount[hit_idx_q] == P_FULL) begin
          acc_status = ST_DROPPED;
        end else begin
          acc_status = ST_Q_PRIV;
          p_we       = 1'b1;
        end
      end else begin
        acc_worker = '0;
        if (scount == S_FULL) begin
          acc_status = ST_DROPPED;
        end else begin
          acc_status = ST_Q_SHARED;
          s_we       = 1'b1;
        end
      end
    end else if (halt) begin
      acc_status = ST_STOPPED;
    end else if (!wk_ok) begin
      acc_status = ST_NONE;
    end else if (pcount[widx] != '0) begin
      acc_status = ST_FROM_PRIV;
      p_re       = 1'b1;
    end else begin
      // private queue drained: drop the binding, try the shared queue
      clr_bind = 1'b1;
      if (scount != '0) begin
        acc_status = ST_FROM_SHARED;
        s_re       = 1'b1;
      end
    end
  end

  assign p_addr = {p_sel, p_we ? ptail[p_sel] : phead[p_sel]};
  assign s_addr = s_we ? stail : shead;

  always_ff @(posedge clk) begin
    if (cmd.access && p_we) pmem[p_addr] <= item_q;
    if (cmd.access && p_re) prd <= pmem[p_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.access && s_we) smem[s_addr] <= item_q;
    if (cmd.access && s_re) srd <= smem[s_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      halt      <= 1'b0;
      shead     <= '0;
      stail     <= '0;
      scount    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < WORKERS; i++) begin
        bind_valid[i] <= 1'b0;
        phead[i]      <= '0;
        ptail[i]      <= '0;
        pcount[i]     <= '0;
      end
    end else begin
      if (cfg_we) halt <= cfg_wdata;
      if (cmd.access) begin
        if (p_we) begin
          ptail[p_sel]  <= (ptail[p_sel] == P_LAST) ? '0 : ptail[p_sel] + 1'b1;
          pcount[p_sel] <= pcount[p_sel] + 1'b1;
        end
        if (p_re) begin
          phead[p_sel]  <= (phead[p_sel] == P_LAST) ? '0 : phead[p_sel] + 1'b1;
          pcount[p_sel] <= pcount[p_sel] - 1'b1;
        end
        if (s_we) begin
          stail  <= (stail == S_LAST) ? '0 : stail + 1'b1;
          scount <= scount + 1'b1;
        end
        if (s_re) begin
          shead  <= (shead == S_LAST) ? '0 : shead + 1'b1;
          scount <= scount - 1'b1;
        end
        if (clr_bind) bind_valid[widx] <= 1'b0;
      end
      // rebinding waits for the shared read data
      if (cmd.load && res_status == ST_FROM_SHARED) bind_valid[widx] <= 1'b1;
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= opcode;
      conn_q   <= CW'(conn_id);
      client_q <= client_tag;
      tag_q    <= item_tag;
      wk_q     <= worker;
    end
    if (cmd.lookup) begin
      hit_q     <= hit;
      hit_idx_q <= hit_idx;
    end
    if (cmd.access) begin
      res_status <= acc_status;
      res_worker <= acc_worker;
    end
    if (cmd.load) begin
      status        <= res_status;
      target_worker <= res_worker;
      unique case (res_status)
        ST_Q_PRIV, ST_Q_SHARED, ST_DROPPED: begin
          out_conn_id    <= CONN_W'(conn_q);
          out_client_tag <= client_q;
          out_item_tag   <= tag_q;
        end
        ST_FROM_PRIV: begin
          out_conn_id    <= CONN_W'(prd[IW-1 -: CW]);
          out_client_tag <= prd[2*TAG_W-1:TAG_W];
          out_item_tag   <= prd[TAG_W-1:0];
        end
        ST_FROM_SHARED: begin
          out_conn_id    <= CONN_W'(srd[IW-1 -: CW]);
          out_client_tag <= srd[2*TAG_W-1:TAG_W];
          out_item_tag   <= srd[TAG_W-1:0];
        end
        default: begin
          out_conn_id    <= '0;
          out_client_tag <= '0;
          out_item_tag   <= '0;
        end
      endcase
      if (res_status == ST_FROM_SHARED) bind_conn[widx] <= srd[IW-1 -: CW];
    end
  end

endmodule

/* hdl/connection_affinity_dispatcher.sv */
// Top level of the connection affinity dispatcher.
// Depends on cad_pkg, cad_req_if, cad_rsp_if, cad_ctrl and cad_datapath.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | opcode, conn_id, client_tag, item_tag, worker
//  rsp     | out | valid/ready      | status, target_worker, out_conn_id, tags
//  cfg     | in  | cfg_we (no wait) | cfg_wdata = halt
//
// Each request goes through 4 steps: capture, binding compare (registered), FIFO
// memory access, and the registered memory read feeding the result register.
// The next request is taken while the previous result still waits on rsp;
// a stalled rsp holds the sequencer in its last step.
// Reset (rst, synchronous) unbinds all workers and empties every FIFO at once;
// FIFO storage is not cleared.
module connection_affinity_dispatcher import cad_pkg::*; #(
  parameter int WORKERS       = 4,
  parameter int PRIVATE_DEPTH = 16,
  parameter int SHARED_DEPTH  = 64,
  parameter int CONN_BITS     = 10
) (
  input  logic      clk,
  input  logic      rst,
  cad_req_if.sink   req,
  cad_rsp_if.source rsp,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic out_free;

  assign sts.in_valid = req.valid;
  assign sts.out_free = out_free;

  cad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .in_ready (req.ready),
    .cmd      (cmd)
  );

  cad_datapath #(
    .WORKERS       (WORKERS),
    .PRIVATE_DEPTH (PRIVATE_DEPTH),
    .SHARED_DEPTH  (SHARED_DEPTH),
    .CONN_BITS     (CONN_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .opcode         (req.opcode),
    .conn_id        (req.conn_id),
    .client_tag     (req.client_tag),
    .item_tag       (req.item_tag),
    .worker         (req.worker),
    .out_ready      (rsp.ready),
    .out_free       (out_free),
    .out_valid      (rsp.valid),
    .status         (rsp.status),
    .target_worker  (rsp.target_worker),
    .out_conn_id    (rsp.out_conn_id),
    .out_client_tag (rsp.out_client_tag),
    .out_item_tag   (rsp.out_item_tag)
  );

  // one request in flight at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // a new result only appears from a finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.load))
    else $error("result raised without a finish step");

endmodule

/* tb/connection_affinity_dispatcher_tb.sv */
// Self-checking testbench for connection_affinity_dispatcher: directed and random
// submit/fetch traffic with random stalls on both channels, checked by a predictor.
// Depends on cad_pkg, cad_req_if, cad_rsp_if and the dispatcher RTL.
`timescale 1ns / 100ps

module connection_affinity_dispatcher_tb;
  import cad_pkg::*;

  localparam int N_WORKERS  = 4;
  localparam int PRIV_SLOTS = 16;
  localparam int POOL_SLOTS = 64;
  localparam int CONN_SEL_W = 10;

  typedef struct {
    logic [CONN_W-1:0] conn;
    logic [TAG_W-1:0]  client;
    logic [TAG_W-1:0]  tag;
  } job_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [WORKER_W-1:0] worker;
    logic [CONN_W-1:0]   conn;
    logic [TAG_W-1:0]    client;
    logic [TAG_W-1:0]    tag;
  } answer_t;

  // Tracks bindings and queue contents, predicts each answer in request order.
  class dispatch_tracker;
    bit                halt_on;
    bit                bound [N_WORKERS];
    logic [CONN_W-1:0] bound_conn [N_WORKERS];
    job_t              priv_jobs [N_WORKERS][$];
    job_t              shared_jobs [$];
    answer_t           awaited [$];
    int                failures;

    function int pending_count();
      return awaited.size();
    endfunction

    function void note_request(logic op, logic [CONN_W-1:0] conn, logic [TAG_W-1:0] client,
                               logic [TAG_W-1:0] tag, logic [WORKER_W-1:0] w);
      answer_t a;
      job_t    j;
      bit      hit;
      a = '{default: '0};
      if (op == OP_SUBMIT) begin
        j.conn   = CONN_W'(conn & ((1 << CONN_SEL_W) - 1));
        j.client = client;
        j.tag    = tag;
        a.conn   = j.conn;
        a.client = j.client;
        a.tag    = j.tag;
        hit = 1'b0;
        for (int i = 0; i < N_WORKERS; i++) begin
          if (!hit && bound[i] && bound_conn[i] == j.conn) begin
            hit = 1'b1;
            a.worker = WORKER_W'(i);
            if (priv_jobs[i].size() >= PRIV_SLOTS) begin
              a.status = ST_DROPPED;
            end else begin
              priv_jobs[i].push_back(j);
              a.status = ST_Q_PRIV;
            end
          end
        end
        if (!hit) begin
          if (shared_jobs.size() >= POOL_SLOTS) begin
            a.status = ST_DROPPED;
          end else begin
            shared_jobs.push_back(j);
            a.status = ST_Q_SHARED;
          end
        end
      end else begin
        a.worker = w;
        if (halt_on) begin
          a.status = ST_STOPPED;
        end else if (w >= N_WORKERS) begin
          a.status = ST_NONE;
        end else if (priv_jobs[w].size() > 0) begin
          j = priv_jobs[w].pop_front();
          a.status = ST_FROM_PRIV;
          a.conn = j.conn; a.client = j.client; a.tag = j.tag;
        end else begin
          // empty private queue drops the binding before looking at shared work
          bound[w] = 1'b0;
          bound_conn[w] = '0;
          if (shared_jobs.size() > 0) begin
            j = shared_jobs.pop_front();
            bound[w] = 1'b1;
            bound_conn[w] = j.conn;
            a.status = ST_FROM_SHARED;
            a.conn = j.conn; a.client = j.client; a.tag = j.tag;
          end else begin
            a.status = ST_NONE;
          end
        end
      end
      awaited.push_back(a);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_response(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        $error("response with no request outstanding: status %0d", got.status);
        failures++;
        return;
      end
      want = awaited.pop_front();
      field_ok("status", want.status, got.status);
      field_ok("target_worker", want.worker, got.worker);
      field_ok("out_conn_id", want.conn, got.conn);
      field_ok("out_client_tag", want.client, got.client);
      field_ok("out_item_tag", want.tag, got.tag);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  bit   calm;

  cad_req_if req_ch ();
  cad_rsp_if rsp_ch ();

  dispatch_tracker tracker = new();

  connection_affinity_dispatcher #(
    .WORKERS      (N_WORKERS),
    .PRIVATE_DEPTH(PRIV_SLOTS),
    .SHARED_DEPTH (POOL_SLOTS),
    .CONN_BITS    (CONN_SEL_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("connection_affinity_dispatcher regression: fail");
    $finish;
  end

  // response side: random back-pressure, compare every transfer
  initial begin
    answer_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.worker = rsp_ch.target_worker;
        got.conn   = rsp_ch.out_conn_id;
        got.client = rsp_ch.out_client_tag;
        got.tag    = rsp_ch.out_item_tag;
        tracker.check_response(got);
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_request(input logic op, input logic [CONN_W-1:0] conn,
                              input logic [TAG_W-1:0] client, input logic [TAG_W-1:0] tag,
                              input logic [WORKER_W-1:0] w);
    while (!calm && $urandom_range(99) < 15) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.conn_id    <= conn;
    req_ch.client_tag <= client;
    req_ch.item_tag   <= tag;
    req_ch.worker     <= w;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, conn, client, tag, w);
  endtask

  // halt only changes once every answer is back and the pipeline has drained
  task automatic write_halt(input logic v);
    req_ch.valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.halt_on = v;
  endtask

  initial begin
    int                submit_pct [10];
    bit                halt_plan [10];
    logic [CONN_W-1:0] pool [4];
    logic [CONN_W-1:0] conn;
    logic              op;
    int                n;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_SUBMIT;
    req_ch.conn_id    <= '0;
    req_ch.client_tag <= '0;
    req_ch.item_tag   <= '0;
    req_ch.worker     <= '0;
    calm = 1'b0;
    submit_pct = '{50, 95, 80, 20, 60, 10, 70, 95, 40, 50};
    halt_plan  = '{0, 0, 1, 0, 0, 1, 0, 1, 0, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_halt(1'b0);
    // empty fetches, then shared work that binds workers
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd3);
    send_request(OP_SUBMIT, 10'd0, 16'h0000, 16'h0000, 2'd0);
    send_request(OP_SUBMIT, 10'h3FF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd1);
    send_request(OP_SUBMIT, 10'd0, 16'h1234, 16'hABCD, 2'd2);
    send_request(OP_SUBMIT, 10'h3FF, 16'h5A5A, 16'hA5A5, 2'd1);
    send_request(OP_SUBMIT, 10'd5, 16'h0F0F, 16'hF0F0, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd0);
    // private empty: binding moves to the shared item's connection
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd2);
    send_request(OP_SUBMIT, 10'd5, 16'h8001, 16'h7FFE, 2'd0);
    send_request(OP_SUBMIT, 10'h3FF, 16'h00FF, 16'hFF00, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd1);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd1);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd1);
    // two workers bound to one connection: lowest index takes the item
    send_request(OP_SUBMIT, 10'd7, 16'h1111, 16'h2222, 2'd0);
    send_request(OP_SUBMIT, 10'd7, 16'h3333, 16'h4444, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd2);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd1);
    send_request(OP_SUBMIT, 10'd7, 16'h5555, 16'h6666, 2'd3);
    write_halt(1'b1);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd0);
    send_request(OP_SUBMIT, 10'd5, 16'hC3C3, 16'h3C3C, 2'd0);
    send_request(OP_FETCH, 10'd0, 16'h0, 16'h0, 2'd3);

    // random phases: small connection pools keep bindings hot so queues fill
    for (int p = 0; p < 10; p++) begin
      write_halt(halt_plan[p]);
      calm = (p == 4);
      for (int k = 0; k < 4; k++) pool[k] = CONN_W'($urandom_range(1023));
      n = (p == 4) ? 100 : 45;
      repeat (n) begin
        op = ($urandom_range(99) < submit_pct[p]) ? OP_SUBMIT : OP_FETCH;
        conn = ($urandom_range(99) < 85) ? pool[2'($urandom_range(3))]
                                         : CONN_W'($urandom_range(1023));
        send_request(op, conn, TAG_W'($urandom_range(16'hFFFF)),
                     TAG_W'($urandom_range(16'hFFFF)), WORKER_W'($urandom_range(3)));
      end
    end
    calm = 1'b0;

    req_ch.valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("connection_affinity_dispatcher regression: pass");
    end else begin
      $display("connection_affinity_dispatcher regression: fail");
    end
    $finish;
  end

endmodule
